// ===== sv/sdnp_pkg.sv =====
// sdnp_pkg: shared constants, types and the control program of the neighbor pick
// used by the channel interfaces, the top level and the checker
// no dependencies
package sdnp_pkg;

    // default widths of the terrain and coordinate fields
    localparam int HEIGHT_BITS_DEF = 16;
    localparam int COORD_BITS_DEF  = 12;

    // fixed field widths
    localparam int RAD_W  = 8;
    localparam int DIVR_W = 16;
    localparam int OUT_W  = 14;
    localparam int CNT_W  = 4;
    localparam int CALC_W = 18;

    // neighborhood layout, raster order, centre is cell 4
    localparam int NUM_NBR  = 8;
    localparam int NUM_CELL = 9;
    localparam logic [3:0] CENTRE_CELL = 4'd4;

    // slope scaling
    localparam int ORTHO_SCALE  = 100;
    localparam int DIAG_SCALE   = 141;
    localparam int WEIGHT_SCALE = 100;

    // tie-break lfsr, galois form shifting right
    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    // offset codes of a cell along one axis
    localparam logic [1:0] OFF_ZERO = 2'b00;
    localparam logic [1:0] OFF_POS  = 2'b01;
    localparam logic [1:0] OFF_NEG  = 2'b11;

    // jump conditions of the sequencer
    localparam logic [2:0] JC_NONE     = 3'd0;
    localparam logic [2:0] JC_NO_IN    = 3'd1;
    localparam logic [2:0] JC_BUSY     = 3'd2;
    localparam logic [2:0] JC_K_MORE   = 3'd3;
    localparam logic [2:0] JC_NO_TIE   = 3'd4;
    localparam logic [2:0] JC_OUT_FULL = 3'd5;

    // program step addresses
    localparam int NUM_STEPS = 9;
    localparam logic [3:0] STEP_IDLE  = 4'd0;
    localparam logic [3:0] STEP_LOAD  = 4'd1;
    localparam logic [3:0] STEP_WWAIT = 4'd2;
    localparam logic [3:0] STEP_STORE = 4'd3;
    localparam logic [3:0] STEP_TALLY = 4'd4;
    localparam logic [3:0] STEP_MOD   = 4'd5;
    localparam logic [3:0] STEP_MWAIT = 4'd6;
    localparam logic [3:0] STEP_PICK  = 4'd7;
    localparam logic [3:0] STEP_EMIT  = 4'd8;
    localparam logic [3:0] STEP_LAST  = STEP_EMIT;

    // one control word
    typedef struct packed {
        logic       in_rdy;
        logic       div_wgt;
        logic       div_mod;
        logic       store_w;
        logic       tally;
        logic       pick;
        logic       emit;
        logic [2:0] jmp_cond;
        logic [3:0] target;
    } t_uop;

    // control program: in_rdy, div_wgt, div_mod, store_w, tally, pick, emit, cond, target
    localparam t_uop UCODE [0:NUM_STEPS-1] = '{
        '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, JC_NO_IN,    STEP_IDLE},
        '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, JC_NONE,     STEP_IDLE},
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, JC_BUSY,     STEP_WWAIT},
        '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, JC_K_MORE,   STEP_LOAD},
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, JC_NONE,     STEP_IDLE},
        '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, JC_NO_TIE,   STEP_PICK},
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, JC_BUSY,     STEP_MWAIT},
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, JC_NONE,     STEP_IDLE},
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, JC_OUT_FULL, STEP_EMIT}
    };

    // raster cell of neighbor slot k (slots skip the centre)
    function automatic logic [3:0] nbr_cell(input logic [2:0] k);
        logic [3:0] c;
        c = {1'b0, k};
        if (k >= 3'd4) begin
            c = {1'b0, k} + 4'd1;
        end
        return c;
    endfunction

    // diagonal neighbor slots: nw, ne, sw, se
    function automatic logic nbr_diag(input logic [2:0] k);
        logic d;
        case (k)
            3'd0, 3'd2, 3'd5, 3'd7: d = 1'b1;
            default:                d = 1'b0;
        endcase
        return d;
    endfunction

    // column offset of a raster cell
    function automatic logic [1:0] cell_dx(input logic [3:0] c);
        logic [1:0] o;
        case (c)
            4'd0, 4'd3, 4'd6: o = OFF_NEG;
            4'd2, 4'd5, 4'd8: o = OFF_POS;
            default:          o = OFF_ZERO;
        endcase
        return o;
    endfunction

    // row offset of a raster cell
    function automatic logic [1:0] cell_dy(input logic [3:0] c);
        logic [1:0] o;
        case (c)
            4'd0, 4'd1, 4'd2: o = OFF_NEG;
            4'd6, 4'd7, 4'd8: o = OFF_POS;
            default:          o = OFF_ZERO;
        endcase
        return o;
    endfunction

endpackage

// ===== sv/sdnp_in_if.sv =====
// sdnp_in_if: valid/ready channel carrying one centre cell with its neighborhood
// depends on sdnp_pkg for the default widths
interface sdnp_in_if #(
    parameter int HEIGHT_BITS = sdnp_pkg::HEIGHT_BITS_DEF,
    parameter int COORD_BITS  = sdnp_pkg::COORD_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [COORD_BITS-1:0]  pos_x;
    logic [COORD_BITS-1:0]  pos_y;
    logic [HEIGHT_BITS-1:0] height_c;
    logic [HEIGHT_BITS-1:0] height_nw;
    logic [HEIGHT_BITS-1:0] height_n;
    logic [HEIGHT_BITS-1:0] height_ne;
    logic [HEIGHT_BITS-1:0] height_w;
    logic [HEIGHT_BITS-1:0] height_e;
    logic [HEIGHT_BITS-1:0] height_sw;
    logic [HEIGHT_BITS-1:0] height_s;
    logic [HEIGHT_BITS-1:0] height_se;
    logic [8:0]             visited_mask;

    modport source (
        output valid, pos_x, pos_y, height_c, height_nw, height_n, height_ne,
               height_w, height_e, height_sw, height_s, height_se, visited_mask,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, height_c, height_nw, height_n, height_ne,
               height_w, height_e, height_sw, height_s, height_se, visited_mask,
        output ready
    );
endinterface

// ===== sv/sdnp_out_if.sv =====
// sdnp_out_if: valid/ready channel carrying the chosen cell and its tie count
// depends on sdnp_pkg for the field widths
interface sdnp_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [sdnp_pkg::OUT_W-1:0]  next_x;
    logic signed [sdnp_pkg::OUT_W-1:0]  next_y;
    logic [sdnp_pkg::CNT_W-1:0]         tie_count;

    modport source (output valid, next_x, next_y, tie_count, input ready);
    modport sink   (input valid, next_x, next_y, tie_count, output ready);
endinterface

// ===== sv/sdnp_div.sv =====
// sdnp_div: unsigned restoring divider, two quotient bits per cycle
// standalone, used by the top level for the slope weights and the tie draw
module sdnp_div #(
    parameter int DW = 23,
    parameter int VW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_busy,
    output logic [DW-1:0] o_quo,
    output logic [VW-1:0] o_rem
);
    localparam int NIT = (DW + 1) / 2;
    localparam int DWP = 2 * NIT;
    localparam int CW  = $clog2(NIT + 1);

    logic [DWP-1:0] r_q;
    logic [VW-1:0]  r_r;
    logic [VW-1:0]  r_d;
    logic [CW-1:0]  r_cnt;
    logic           r_busy;
    logic [DWP-1:0] n_q;
    logic [VW-1:0]  n_r;

    // two shift-subtract steps
    always_comb begin
        logic [VW:0] t;
        n_q = r_q;
        n_r = r_r;
        for (int i = 0; i < 2; i++) begin
            t   = {n_r, n_q[DWP-1]};
            n_q = {n_q[DWP-2:0], 1'b0};
            if (t >= {1'b0, r_d}) begin
                t      = t - {1'b0, r_d};
                n_q[0] = 1'b1;
            end
            n_r = t[VW-1:0];
        end
    end

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(NIT);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // operand and partial result registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= DWP'(i_dividend);
            r_r <= '0;
            r_d <= i_divisor;
        end else if (r_busy) begin
            r_q <= n_q;
            r_r <= n_r;
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_q[DW-1:0];
    assign o_rem  = r_r;
endmodule

// ===== sv/steepest_descent_neighbor_pick.sv =====
// Steepest-descent neighbor pick. One input beat carries a centre cell, its height,
// the eight neighbor heights sampled step_radius cells away and a visited mask; one
// output beat gives the cell of steepest descent among the unvisited cells (ties
// broken by a 16-bit lfsr) and the tie count, or the centre with a count of 0 when
// no unvisited cell reaches the minimum slope. A microcoded sequencer runs each item
// through one shared restoring divider that yields two bits per cycle; eight slope
// divisions and the tie draw modulo all queue on that divider, and the modulo is
// skipped when no cell ties. The next item is taken as soon as the previous result
// sits in the output register.
// depends on sdnp_pkg, sdnp_in_if, sdnp_out_if and sdnp_div
module steepest_descent_neighbor_pick #(
    parameter int HEIGHT_BITS = sdnp_pkg::HEIGHT_BITS_DEF,
    parameter int COORD_BITS  = sdnp_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [sdnp_pkg::RAD_W-1:0]   i_cfg_wdata,
    sdnp_in_if.sink                      i_item,
    sdnp_out_if.source                   o_res
);
    import sdnp_pkg::*;

    localparam int HB    = HEIGHT_BITS;
    localparam int DIV_W = (HB + 7 > 16) ? HB + 7 : 16;
    localparam int W_W   = DIV_W + 1;

    // sequencer
    logic [3:0]  r_pc;
    logic [3:0]  n_pc;
    t_uop        uop;
    logic        jmp;
    logic        div_busy;

    // captured item
    logic [COORD_BITS-1:0] r_px;
    logic [COORD_BITS-1:0] r_py;
    logic [HB-1:0]         r_hc;
    logic [HB-1:0]         r_hgt [NUM_NBR];
    logic [8:0]            r_vis;

    // working state
    logic [RAD_W-1:0]        r_radius;
    logic [15:0]             r_lfsr;
    logic [2:0]              r_k;
    logic signed [W_W-1:0]   r_wgt [NUM_NBR];
    logic signed [W_W-1:0]   r_min;
    logic [NUM_CELL-1:0]     r_tie;
    logic [CNT_W-1:0]        r_cnt;
    logic [OUT_W-1:0]        r_nx;
    logic [OUT_W-1:0]        r_ny;

    // output register
    logic                    r_ovld;
    logic [OUT_W-1:0]        r_onx;
    logic [OUT_W-1:0]        r_ony;
    logic [CNT_W-1:0]        r_otc;

    logic in_acc;
    logic out_free;

    assign uop      = UCODE[r_pc];
    assign in_acc   = i_item.valid && uop.in_rdy;
    assign out_free = !r_ovld || o_res.ready;

    // jump decision and next step
    always_comb begin
        case (uop.jmp_cond)
            JC_NO_IN:    jmp = !in_acc;
            JC_BUSY:     jmp = div_busy;
            JC_K_MORE:   jmp = (r_k != 3'(NUM_NBR - 1));
            JC_NO_TIE:   jmp = (r_cnt == '0);
            JC_OUT_FULL: jmp = !out_free;
            default:     jmp = 1'b0;
        endcase
        if (jmp) begin
            n_pc = uop.target;
        end else if (r_pc == STEP_LAST) begin
            n_pc = STEP_IDLE;
        end else begin
            n_pc = r_pc + 4'd1;
        end
    end

    // slope operand of the current neighbor
    logic [HB-1:0]       h_cur;
    logic signed [HB:0]  diff;
    logic                neg;
    logic [HB-1:0]       mag;
    logic [DIVR_W-1:0]   slope_den;

    always_comb begin
        h_cur = r_hgt[r_k];
        diff  = $signed({1'b0, h_cur}) - $signed({1'b0, r_hc});
        neg   = diff[HB];
        mag   = neg ? HB'((HB + 1)'(0) - diff) : diff[HB-1:0];
        if (r_radius == '0) begin
            slope_den = DIVR_W'(1);
        end else if (nbr_diag(r_k)) begin
            slope_den = DIVR_W'(r_radius) * DIVR_W'(DIAG_SCALE);
        end else begin
            slope_den = DIVR_W'(r_radius) * DIVR_W'(ORTHO_SCALE);
        end
    end

    // shared divider
    logic              div_start;
    logic [DIV_W-1:0]  div_a;
    logic [DIVR_W-1:0] div_b;
    logic [DIV_W-1:0]  div_quo;
    logic [DIVR_W-1:0] div_rem;

    assign div_start = uop.div_wgt || (uop.div_mod && r_cnt != '0);
    assign div_a     = uop.div_mod ? DIV_W'(r_lfsr)
                                   : DIV_W'(mag) * DIV_W'(WEIGHT_SCALE);
    assign div_b     = uop.div_mod ? DIVR_W'(r_cnt) : slope_den;

    sdnp_div #(
        .DW (DIV_W),
        .VW (DIVR_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_busy     (div_busy),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    // signed weight from the quotient
    logic signed [W_W-1:0] w_new;
    logic                  w_open;

    assign w_new  = neg ? -$signed(W_W'(div_quo)) : $signed(W_W'(div_quo));
    assign w_open = !r_vis[nbr_cell(r_k)];

    // tie mask and count over all nine cells
    logic [NUM_CELL-1:0] tie_v;
    logic [CNT_W-1:0]    tie_n;

    always_comb begin
        tie_n = '0;
        for (int k = 0; k < NUM_NBR; k++) begin
            tie_v[nbr_cell(3'(k))] = !r_vis[nbr_cell(3'(k))] && (r_wgt[k] == r_min);
        end
        tie_v[CENTRE_CELL] = !r_vis[CENTRE_CELL] && (r_min == '0);
        for (int c = 0; c < NUM_CELL; c++) begin
            tie_n = tie_n + CNT_W'(tie_v[c]);
        end
    end

    // pick the tie entry and form the cell position
    logic [CNT_W-1:0]  pick_idx;
    logic [CNT_W-1:0]  run;
    logic [3:0]        sel;
    logic [CALC_W-1:0] x_w;
    logic [CALC_W-1:0] y_w;
    logic [CALC_W-1:0] rad_w;

    always_comb begin
        pick_idx = r_cnt - CNT_W'(1) - CNT_W'(div_rem);
        run      = '0;
        sel      = CENTRE_CELL;
        for (int c = 0; c < NUM_CELL; c++) begin
            if (r_tie[c] && run == pick_idx) begin
                sel = 4'(c);
            end
            run = run + CNT_W'(r_tie[c]);
        end
        rad_w = CALC_W'(r_radius);
        case (cell_dx(sel))
            OFF_NEG: x_w = CALC_W'(r_px) - rad_w;
            OFF_POS: x_w = CALC_W'(r_px) + rad_w;
            default: x_w = CALC_W'(r_px);
        endcase
        case (cell_dy(sel))
            OFF_NEG: y_w = CALC_W'(r_py) - rad_w;
            OFF_POS: y_w = CALC_W'(r_py) + rad_w;
            default: y_w = CALC_W'(r_py);
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= STEP_IDLE;
            r_radius <= RAD_W'(1);
            r_lfsr   <= LFSR_SEED;
            r_ovld   <= 1'b0;
        end else begin
            r_pc <= n_pc;
            if (i_cfg_we) begin
                r_radius <= i_cfg_wdata;
            end
            if (uop.pick && r_cnt != '0) begin
                r_lfsr <= r_lfsr[0] ? ((r_lfsr >> 1) ^ LFSR_TAPS) : (r_lfsr >> 1);
            end
            if (uop.emit && out_free) begin
                r_ovld <= 1'b1;
            end else if (o_res.ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_px     <= i_item.pos_x;
            r_py     <= i_item.pos_y;
            r_hc     <= i_item.height_c;
            r_hgt[0] <= i_item.height_nw;
            r_hgt[1] <= i_item.height_n;
            r_hgt[2] <= i_item.height_ne;
            r_hgt[3] <= i_item.height_w;
            r_hgt[4] <= i_item.height_e;
            r_hgt[5] <= i_item.height_sw;
            r_hgt[6] <= i_item.height_s;
            r_hgt[7] <= i_item.height_se;
            r_vis    <= i_item.visited_mask;
            r_k      <= '0;
            r_min    <= '0;
        end
        if (uop.store_w) begin
            r_wgt[r_k] <= w_new;
            r_k        <= r_k + 3'd1;
            if (w_open && w_new < r_min) begin
                r_min <= w_new;
            end
        end
        if (uop.tally) begin
            r_tie <= tie_v;
            r_cnt <= tie_n;
        end
        if (uop.pick) begin
            r_nx <= x_w[OUT_W-1:0];
            r_ny <= y_w[OUT_W-1:0];
        end
        if (uop.emit && out_free) begin
            r_onx <= r_nx;
            r_ony <= r_ny;
            r_otc <= r_cnt;
        end
    end

    // ports
    assign i_item.ready    = uop.in_rdy;
    assign o_res.valid     = r_ovld;
    assign o_res.next_x    = $signed(r_onx);
    assign o_res.next_y    = $signed(r_ony);
    assign o_res.tie_count = r_otc;
endmodule

// ===== sv/sdnp_chk.sv =====
// sdnp_chk: port-level checks of the neighbor pick, bound to the top level
// depends on sdnp_pkg and steepest_descent_neighbor_pick
module sdnp_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               i_in_ready,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic signed [sdnp_pkg::OUT_W-1:0]  i_next_x,
    input logic signed [sdnp_pkg::OUT_W-1:0]  i_next_y,
    input logic [sdnp_pkg::CNT_W-1:0]         i_tie_count
);
    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_next_x)
            && $stable(i_next_y) && $stable(i_tie_count))
        else $error("result beat changed while stalled");

    // at most nine cells can tie
    a_tie_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_tie_count <= 4'd9)
        else $error("tie count out of range");

    // an accepted beat keeps the block busy on the next cycle
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second beat taken while working");

    // reset leaves no result pending
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");
endmodule

bind steepest_descent_neighbor_pick sdnp_chk u_sdnp_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_next_x    (o_res.next_x),
    .i_next_y    (o_res.next_y),
    .i_tie_count (o_res.tie_count)
);
